// ===== hw/rtl/kst_pkg.sv =====
// Shared types and constants for the key state tracker.
// Holds the channel payload structs, the bitmap port struct and key code translation.
// No dependencies.
package kst_pkg;

	localparam int unsigned MAP_WORDS = 8;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned BIT_W     = 5;
	localparam int unsigned CODE_W    = 8;

	localparam logic [1:0] MODE_EVENT    = 2'd0;
	localparam logic [1:0] MODE_ACTIVATE = 2'd1;
	localparam logic [1:0] MODE_QUERY    = 2'd2;
	localparam logic [1:0] MODE_FRAME    = 2'd3;

	localparam logic [7:0] KEY_ENTER        = 8'h0D;
	localparam logic [7:0] KEY_SHIFT        = 8'h10;
	localparam logic [7:0] KEY_CTRL         = 8'h11;
	localparam logic [7:0] KEY_ALT          = 8'h12;
	localparam logic [7:0] KEY_LSHIFT       = 8'hA0;
	localparam logic [7:0] KEY_RSHIFT       = 8'hA1;
	localparam logic [7:0] KEY_LCTRL        = 8'hA2;
	localparam logic [7:0] KEY_RCTRL        = 8'hA3;
	localparam logic [7:0] KEY_LALT         = 8'hA4;
	localparam logic [7:0] KEY_RALT         = 8'hA5;
	localparam logic [7:0] KEY_NUMPAD_ENTER = 8'hE8;

	typedef struct packed {
		logic [1:0] mode;
		logic [8:0] key_code;
		logic       is_down;
		logic       extended;
	} in_t;

	typedef struct packed {
		logic       key_held;
		logic       key_pressed;
		logic       key_released;
		logic [7:0] last_pressed;
		logic [7:0] last_released;
	} out_t;

	typedef struct packed {
		logic              clr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0] wr_data;
	} map_req_t;

	// left/right or keypad variant of the generic modifier and enter codes
	function automatic logic [7:0] translate(input logic [7:0] code, input logic ext);
		logic [7:0] tr;
		tr = code;
		case (code)
			KEY_ENTER: tr = ext ? KEY_NUMPAD_ENTER : KEY_ENTER;
			KEY_SHIFT: tr = ext ? KEY_RSHIFT : KEY_LSHIFT;
			KEY_CTRL:  tr = ext ? KEY_RCTRL : KEY_LCTRL;
			KEY_ALT:   tr = ext ? KEY_RALT : KEY_LALT;
			default:   tr = code;
		endcase
		return tr;
	endfunction

endpackage

// ===== hw/rtl/kst_map.sv =====
// One 256-bit key bitmap: 8 x 32 synchronous memory with registered read data.
// Per-word valid flags give an instant clear; an invalid word reads as zero.
// Depends on kst_pkg.
module kst_map (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kst_pkg::map_req_t                 req,
	output logic [kst_pkg::WORD_W-1:0]        rd_data
);
	import kst_pkg::*;

	logic [WORD_W-1:0]    mem [MAP_WORDS];
	logic [WORD_W-1:0]    rd_raw_q;
	logic [MAP_WORDS-1:0] vld_q;
	logic                 rd_vld_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr] && !req.clr;
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_raw_q : '0;

`ifndef SYNTH
	a_no_clr_during_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.clr && req.wr_en))
		else $error("bitmap clear collides with a write");
	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |=> vld_q[$past(req.wr_addr)])
		else $error("written word not marked valid");
	a_same_word_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.wr_en && req.rd_en && req.wr_addr == req.rd_addr))
		else $error("read and write of the same word in one cycle");
`endif

endmodule

// ===== hw/rtl/key_state_tracker_unit.sv =====
// Key state tracker: held / pressed / released bitmaps in three 8 x 32 memories.
// Queries: ST_RD reads all three maps, then ST_QUERY loads the result. Events pass ST_RD and
// ST_WR_A, then ST_WR_B for shift/ctrl/alt and extended enter, whose translated code sits in
// a second held word. Activate and ignored events stay in ST_IDLE; a new item is taken only
// there, after the read-modify-write of the held memory, and a query also waits in place
// while an earlier result is unaccepted. Reset clears all maps at once via word valid flags.
module key_state_tracker_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  kst_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output kst_pkg::out_t out_data
);
	import kst_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_WR_A,
		ST_WR_B,
		ST_QUERY
	} state_t;

	state_t     state_q;
	logic [7:0] code_q;
	logic [7:0] tr_q;
	logic       down_q;
	logic       xlat_q;
	logic       shift_rel_q;
	logic       query_q;
	logic       frame_q;
	logic       qvalid_q;
	logic [7:0] last_down_q;
	logic [7:0] last_up_q;
	logic       out_valid_q;
	out_t       out_data_q;

	map_req_t          held_req;
	map_req_t          pr_req;
	map_req_t          rl_req;
	logic [WORD_W-1:0] held_rd;
	logic [WORD_W-1:0] pr_rd;
	logic [WORD_W-1:0] rl_rd;

	logic              in_xfer;
	logic              activate;
	logic              out_load;
	logic [WORD_W-1:0] code_bit;
	logic [WORD_W-1:0] tr_bit;
	logic [WORD_W-1:0] shift_bits;
	logic [WORD_W-1:0] held_raw_new;
	logic [WORD_W-1:0] held_tr_new;
	logic [7:0]        in_tr;

	kst_map u_held (.clk(clk), .arst_n(arst_n), .req(held_req), .rd_data(held_rd));
	kst_map u_pressed (.clk(clk), .arst_n(arst_n), .req(pr_req), .rd_data(pr_rd));
	kst_map u_released (.clk(clk), .arst_n(arst_n), .req(rl_req), .rd_data(rl_rd));

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign activate  = in_xfer && (in_data.mode == MODE_ACTIVATE);
	assign out_load  = (state_q == ST_QUERY) && (!out_valid_q || out_ready);
	assign in_tr     = translate(in_data.key_code[7:0], in_data.extended);

	assign code_bit   = WORD_W'(1) << code_q[BIT_W-1:0];
	assign tr_bit     = WORD_W'(1) << tr_q[BIT_W-1:0];
	assign shift_bits = (WORD_W'(1) << KEY_LSHIFT[BIT_W-1:0])
		| (WORD_W'(1) << KEY_RSHIFT[BIT_W-1:0]);

	assign held_raw_new = down_q ? (held_rd | code_bit) : (held_rd & ~code_bit);

	always_comb begin
		logic [WORD_W-1:0] w;
		w = shift_rel_q ? (held_rd & ~shift_bits) : held_rd;
		held_tr_new = down_q ? (w | tr_bit) : (w & ~tr_bit);
	end

	always_comb begin
		held_req = '0;
		pr_req   = '0;
		rl_req   = '0;
		held_req.clr = activate;
		pr_req.clr   = activate || (out_load && frame_q);
		rl_req.clr   = activate || (out_load && frame_q);
		unique case (state_q)
			ST_RD: begin
				held_req.rd_en   = 1'b1;
				held_req.rd_addr = code_q[7:BIT_W];
				pr_req.rd_en     = 1'b1;
				pr_req.rd_addr   = tr_q[7:BIT_W];
				rl_req.rd_en     = 1'b1;
				rl_req.rd_addr   = tr_q[7:BIT_W];
			end
			ST_WR_A: begin
				held_req.wr_en   = 1'b1;
				held_req.wr_addr = code_q[7:BIT_W];
				held_req.wr_data = held_raw_new;
				// translated code lives in another word: fetch it for the next cycle
				held_req.rd_en   = xlat_q;
				held_req.rd_addr = tr_q[7:BIT_W];
				pr_req.wr_en     = down_q;
				pr_req.wr_addr   = tr_q[7:BIT_W];
				pr_req.wr_data   = pr_rd | tr_bit;
				rl_req.wr_en     = !down_q;
				rl_req.wr_addr   = tr_q[7:BIT_W];
				rl_req.wr_data   = rl_rd | tr_bit;
			end
			ST_WR_B: begin
				held_req.wr_en   = 1'b1;
				held_req.wr_addr = tr_q[7:BIT_W];
				held_req.wr_data = held_tr_new;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			code_q      <= '0;
			tr_q        <= '0;
			down_q      <= 1'b0;
			xlat_q      <= 1'b0;
			shift_rel_q <= 1'b0;
			query_q     <= 1'b0;
			frame_q     <= 1'b0;
			qvalid_q    <= 1'b0;
			last_down_q <= '0;
			last_up_q   <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else begin
			if (out_valid_q && out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						code_q      <= in_data.key_code[7:0];
						down_q      <= in_data.is_down;
						qvalid_q    <= !in_data.key_code[8];
						shift_rel_q <= (in_data.key_code[7:0] == KEY_SHIFT) && !in_data.is_down;
						frame_q     <= (in_data.mode == MODE_FRAME);
						query_q     <= (in_data.mode == MODE_QUERY) || (in_data.mode == MODE_FRAME);
						case (in_data.mode)
							MODE_EVENT: begin
								tr_q   <= in_tr;
								xlat_q <= (in_tr != in_data.key_code[7:0]);
								if (!in_data.key_code[8]) begin
									state_q <= ST_RD;
								end
							end
							MODE_ACTIVATE: begin
								last_down_q <= '0;
								last_up_q   <= '0;
							end
							default: begin
								tr_q    <= in_data.key_code[7:0];
								xlat_q  <= 1'b0;
								state_q <= ST_RD;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= query_q ? ST_QUERY : ST_WR_A;
				end
				ST_WR_A: begin
					if (down_q) begin
						last_down_q <= tr_q;
					end else begin
						last_up_q <= tr_q;
					end
					state_q <= xlat_q ? ST_WR_B : ST_IDLE;
				end
				ST_WR_B: begin
					state_q <= ST_IDLE;
				end
				ST_QUERY: begin
					if (out_load) begin
						out_valid_q                <= 1'b1;
						out_data_q.key_held        <= qvalid_q && held_rd[code_q[BIT_W-1:0]];
						out_data_q.key_pressed     <= qvalid_q && pr_rd[code_q[BIT_W-1:0]];
						out_data_q.key_released    <= qvalid_q && rl_rd[code_q[BIT_W-1:0]];
						out_data_q.last_pressed    <= last_down_q;
						out_data_q.last_released   <= last_up_q;
						if (frame_q) begin
							last_down_q <= '0;
							last_up_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_wr_b_follows_wr_a: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR_B |-> $past(state_q) == ST_WR_A)
		else $error("second held write without a first");
	a_wr_b_other_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR_B |-> xlat_q && (tr_q[7:BIT_W] != code_q[7:BIT_W]))
		else $error("translated code shares the raw held word");
	a_activate_clears_last: assert property (@(posedge clk) disable iff (!arst_n)
		activate |=> (last_down_q == '0) && (last_up_q == '0))
		else $error("activate left a last key");
	a_query_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QUERY && out_valid_q && !out_ready |=> state_q == ST_QUERY)
		else $error("query result dropped while output stalled");
	a_out_when_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_QUERY)
		else $error("result produced outside a query");
`endif

endmodule

// ===== verif/key_state_tracker_checker.sv =====
`timescale 1ns / 1ps
// Checker for the key state tracker: watches both channels, predicts query results.
// Depends on kst_pkg for the payload structs, mode codes and key codes.
module key_state_tracker_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  kst_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  kst_pkg::out_t out_data,
	output int            mismatches,
	output int            queries_open
);
	import kst_pkg::*;

	logic [255:0] held_keys;
	logic [255:0] pressed_keys;
	logic [255:0] released_keys;
	logic [7:0]   last_down;
	logic [7:0]   last_up;
	out_t         query_results[$];

	initial begin
		mismatches   = 0;
		queries_open = 0;
	end

	// generic enter/modifier codes map onto their left/right or keypad variant
	function automatic logic [7:0] side_code(input logic [7:0] code, input logic ext);
		logic [7:0] res;
		res = code;
		if (code == KEY_ENTER && ext)
			res = KEY_NUMPAD_ENTER;
		else if (code == KEY_SHIFT)
			res = ext ? KEY_RSHIFT : KEY_LSHIFT;
		else if (code == KEY_CTRL)
			res = ext ? KEY_RCTRL : KEY_LCTRL;
		else if (code == KEY_ALT)
			res = ext ? KEY_RALT : KEY_LALT;
		return res;
	endfunction

	task automatic clear_frame_state();
		pressed_keys  = '0;
		released_keys = '0;
		last_down     = '0;
		last_up       = '0;
	endtask

	task automatic clear_all_keys();
		held_keys = '0;
		clear_frame_state();
	endtask

	task automatic apply_key_item(input in_t item);
		logic [7:0] code;
		logic [7:0] tr;
		out_t       res;
		code = item.key_code[7:0];
		case (item.mode)
			MODE_EVENT: begin
				// codes above 255 leave the state alone
				if (!item.key_code[8]) begin
					tr = side_code(code, item.extended);
					if (code == KEY_SHIFT && !item.is_down) begin
						held_keys[KEY_LSHIFT] = 1'b0;
						held_keys[KEY_RSHIFT] = 1'b0;
					end
					held_keys[code] = item.is_down;
					held_keys[tr]   = item.is_down;
					if (item.is_down) begin
						pressed_keys[tr] = 1'b1;
						last_down        = tr;
					end else begin
						released_keys[tr] = 1'b1;
						last_up           = tr;
					end
				end
			end
			MODE_ACTIVATE: clear_all_keys();
			MODE_QUERY, MODE_FRAME: begin
				res.key_held      = !item.key_code[8] && held_keys[code];
				res.key_pressed   = !item.key_code[8] && pressed_keys[code];
				res.key_released  = !item.key_code[8] && released_keys[code];
				res.last_pressed  = last_down;
				res.last_released = last_up;
				query_results.push_back(res);
				if (item.mode == MODE_FRAME)
					clear_frame_state();
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input out_t want);
		mismatches++;
		if (mismatches <= 10)
			$display({"%0t mismatch (%s): expected held %b pressed %b released %b",
				" last %h/%h, got held %b pressed %b released %b last %h/%h"},
				$realtime, what, want.key_held, want.key_pressed, want.key_released,
				want.last_pressed, want.last_released, out_data.key_held,
				out_data.key_pressed, out_data.key_released, out_data.last_pressed,
				out_data.last_released);
	endtask

	always @(posedge clk) begin
		out_t want;
		if (!arst_n) begin
			clear_all_keys();
			query_results.delete();
		end else begin
			// result side first: it can never belong to an input taken at this edge
			if (out_valid && out_ready) begin
				if (query_results.size() == 0) begin
					note_mismatch("no result pending", '0);
				end else begin
					want = query_results.pop_front();
					if (want.key_held !== out_data.key_held
							|| want.key_pressed !== out_data.key_pressed
							|| want.key_released !== out_data.key_released
							|| want.last_pressed !== out_data.last_pressed
							|| want.last_released !== out_data.last_released)
						note_mismatch("field", want);
				end
			end
			if (in_valid && in_ready)
				apply_key_item(in_data);
		end
		queries_open = query_results.size();
	end

endmodule

// ===== verif/key_state_tracker_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for key_state_tracker_unit: clock, reset, stimulus and verdict.
// Depends on kst_pkg, the block and key_state_tracker_checker.
module key_state_tracker_unit_tb;
	import kst_pkg::*;

	localparam int IDLE_LIMIT   = 1000;
	localparam int ITEM_TARGET  = 1450;
	localparam int PAUSE_EVERY  = 400;
	localparam int DRAIN_CYCLES = 24;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_t        in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_t       out_data;
	int         mismatches;
	int         queries_open;
	int         idle_cycles = 0;
	int         feed_calm   = 0;
	int         drain_calm  = 0;
	logic [8:0] recent_code = '0;

	always #2 clk = ~clk;

	key_state_tracker_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	key_state_tracker_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.mismatches  (mismatches),
		.queries_open(queries_open)
	);

	function automatic in_t make_item(input logic [1:0] mode, input logic [8:0] code,
			input logic down, input logic ext);
		in_t item;
		item.mode     = mode;
		item.key_code = code;
		item.is_down  = down;
		item.extended = ext;
		return item;
	endfunction

	// wait before a transfer: mostly random, sometimes a run of back-to-back items
	function automatic int draw_wait(inout int calm);
		int n;
		n = 0;
		if (calm != 0)
			calm--;
		else if ($urandom_range(0, 9) == 0)
			calm = $urandom_range(10, 40);
		else
			n = $urandom_range(0, 18);
		return n;
	endfunction

	function automatic logic [7:0] pick_side_key();
		logic [7:0] k;
		case ($urandom_range(0, 10))
			0:       k = KEY_ENTER;
			1:       k = KEY_SHIFT;
			2:       k = KEY_CTRL;
			3:       k = KEY_ALT;
			4:       k = KEY_LSHIFT;
			5:       k = KEY_RSHIFT;
			6:       k = KEY_LCTRL;
			7:       k = KEY_RCTRL;
			8:       k = KEY_LALT;
			9:       k = KEY_RALT;
			default: k = KEY_NUMPAD_ENTER;
		endcase
		return k;
	endfunction

	function automatic in_t random_item();
		int         pick;
		logic [1:0] mode;
		logic [8:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			mode = MODE_EVENT;
		else if (pick < 82)
			mode = MODE_QUERY;
		else if (pick < 96)
			mode = MODE_FRAME;
		else
			mode = MODE_ACTIVATE;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			code = {1'b0, pick_side_key()};
		else if (pick < 45)
			code = recent_code;
		else if (pick < 60)
			code = 9'($urandom_range(0, 15));
		else if (pick < 92)
			code = 9'($urandom_range(0, 255));
		else
			code = 9'($urandom_range(256, 511));
		return make_item(mode, code, $urandom_range(0, 9) < 6, 1'($urandom_range(0, 1)));
	endfunction

	task automatic feed(input in_t item);
		int gap;
		gap = draw_wait(feed_calm);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// hold off the sender until every query result has come back
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (queries_open != 0) @(negedge clk);
	endtask

	initial begin
		int stall;
		forever begin
			stall = draw_wait(drain_calm);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		in_t item;
		int  counted;
		counted = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		feed(make_item(MODE_QUERY, 9'h00D, 1'b0, 1'b0));
		feed(make_item(MODE_EVENT, 9'h00D, 1'b1, 1'b1));
		feed(make_item(MODE_EVENT, 9'h010, 1'b1, 1'b0));
		feed(make_item(MODE_EVENT, 9'h010, 1'b1, 1'b1));
		feed(make_item(MODE_EVENT, 9'h011, 1'b1, 1'b1));
		feed(make_item(MODE_EVENT, 9'h012, 1'b1, 1'b0));
		feed(make_item(MODE_QUERY, {1'b0, KEY_NUMPAD_ENTER}, 1'b0, 1'b0));
		feed(make_item(MODE_QUERY, {1'b0, KEY_RSHIFT}, 1'b1, 1'b1));
		// releasing plain shift drops both sides
		feed(make_item(MODE_EVENT, 9'h010, 1'b0, 1'b0));
		feed(make_item(MODE_QUERY, {1'b0, KEY_RSHIFT}, 1'b0, 1'b0));
		feed(make_item(MODE_QUERY, 9'h010, 1'b0, 1'b1));
		feed(make_item(MODE_EVENT, 9'h011, 1'b0, 1'b0));
		feed(make_item(MODE_QUERY, {1'b0, KEY_RCTRL}, 1'b0, 1'b0));
		feed(make_item(MODE_EVENT, 9'h000, 1'b1, 1'b0));
		feed(make_item(MODE_EVENT, 9'h0FF, 1'b1, 1'b1));
		feed(make_item(MODE_EVENT, 9'h1FF, 1'b1, 1'b1));
		feed(make_item(MODE_EVENT, 9'h100, 1'b0, 1'b0));
		feed(make_item(MODE_FRAME, 9'h1FF, 1'b1, 1'b1));
		feed(make_item(MODE_QUERY, 9'h0FF, 1'b0, 1'b0));
		feed(make_item(MODE_EVENT, 9'h0FF, 1'b0, 1'b1));
		feed(make_item(MODE_FRAME, 9'h0FF, 1'b0, 1'b0));
		feed(make_item(MODE_QUERY, 9'h000, 1'b0, 1'b0));
		feed(make_item(MODE_ACTIVATE, 9'h1FF, 1'b1, 1'b1));
		feed(make_item(MODE_QUERY, 9'h000, 1'b0, 1'b0));
		feed(make_item(MODE_EVENT, 9'h012, 1'b1, 1'b1));
		feed(make_item(MODE_FRAME, {1'b0, KEY_RALT}, 1'b0, 1'b0));

		while (counted < ITEM_TARGET) begin
			item = random_item();
			if (item.mode == MODE_EVENT && !item.key_code[8])
				recent_code = item.key_code;
			feed(item);
			// events on codes above 255 are dropped by the block
			if (!(item.mode == MODE_EVENT && item.key_code[8])) begin
				counted++;
				if (counted % PAUSE_EVERY == 0)
					settle();
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/kst_pkg.sv
hw/rtl/kst_map.sv
hw/rtl/key_state_tracker_unit.sv
verif/key_state_tracker_checker.sv
verif/key_state_tracker_unit_tb.sv
